### src/r2p_pkg.sv
// ----------------------------------------------------------------------------
// Rectangular to polar conversion: shared types, constants and step functions
// Holds the sample and result formats, the per-stage pipeline record, the
// arctangent table and the CORDIC and square-root step functions.
// ----------------------------------------------------------------------------
package r2p_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int ITERATIONS = 16;

	// Datapath widths.
	localparam int CW = 64;                   // CORDIC x and y
	localparam int AW = 32;                   // angle accumulator
	localparam int SW = 2 * DATA_WIDTH;       // sum of squares and remainder
	localparam int RW = SW + 1;               // root register of the square root
	localparam int PRE_SHIFT = 60 - DATA_WIDTH;
	localparam int ANG_SHIFT = AW - DATA_WIDTH;
	localparam logic [AW-1:0] ANG_HALF = (ANG_SHIFT > 0) ?
		(AW'(1) << ((ANG_SHIFT > 0) ? (ANG_SHIFT - 1) : 0)) : '0;

	// Stage 1 prepares, the CORDIC runs from stage 2, the square root from stage 3.
	localparam int CORDIC_LAST = ITERATIONS + 1;
	localparam int SQRT_LAST = DATA_WIDTH + 2;
	localparam int STAGES = (CORDIC_LAST > SQRT_LAST) ? CORDIC_LAST : SQRT_LAST;

	localparam logic [AW-1:0] ANG_ZERO    = 32'h0000_0000;
	localparam logic [AW-1:0] ANG_HALF_PI = 32'h4000_0000;
	localparam logic [AW-1:0] ANG_PI      = 32'h8000_0000;
	localparam logic [AW-1:0] ANG_NEG_HPI = 32'hC000_0000;

	// round(atan(2^-i) * 2^32 / (2*pi))
	localparam logic [AW-1:0] ATAN_TAB [0:31] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] real_part;
		logic signed [DATA_WIDTH-1:0] imag_part;
	} sample_t;

	typedef struct packed {
		logic        [DATA_WIDTH-1:0] magnitude;
		logic signed [DATA_WIDTH-1:0] phase_angle;
	} result_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [AW-1:0]        z;
		logic [SW-1:0]        sq_re;
		logic [SW-1:0]        sq_im;
		logic [SW-1:0]        rem;
		logic [RW-1:0]        root;
		logic                 is_axis;
		logic [AW-1:0]        axis_z;
	} stage_t;

	// One vectoring micro-rotation; the arithmetic shift floors like the angle math needs.
	function automatic stage_t cordic_step(stage_t d, logic [4:0] i);
		stage_t res;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		res = d;
		dx = d.y >>> i;
		dy = d.x >>> i;
		if (!d.y[CW-1]) begin
			res.x = d.x + dx;
			res.y = d.y - dy;
			res.z = d.z + ATAN_TAB[i];
		end else begin
			res.x = d.x - dx;
			res.y = d.y + dy;
			res.z = d.z - ATAN_TAB[i];
		end
		return res;
	endfunction

	// One digit of the restoring integer square root.
	function automatic stage_t sqrt_step(stage_t d, int j);
		stage_t res;
		logic [RW-1:0] bitv;
		logic [RW-1:0] trial;
		logic [RW-1:0] rem_w;
		res = d;
		bitv = RW'(1) << (SW - 2 - 2 * j);
		trial = d.root + bitv;
		rem_w = {1'b0, d.rem};
		if (rem_w >= trial) begin
			res.rem = SW'(rem_w - trial);
			res.root = (d.root >> 1) + bitv;
		end else begin
			res.root = d.root >> 1;
		end
		return res;
	endfunction

endpackage

### src/r2p_prep.sv
// ----------------------------------------------------------------------------
// Input preparation
// Squares the absolute parts, folds the left half plane onto the right one
// for the CORDIC, and flags samples on an axis with their exact angle.
// ----------------------------------------------------------------------------
module r2p_prep (
	input  r2p_pkg::sample_t sample,
	output r2p_pkg::stage_t  prep
);
	import r2p_pkg::*;

	logic signed [DATA_WIDTH:0]     re_w;
	logic signed [DATA_WIDTH:0]     im_w;
	logic [DATA_WIDTH:0]            are;
	logic [DATA_WIDTH:0]            aim;
	logic [2*DATA_WIDTH+1:0]        prod_re;
	logic [2*DATA_WIDTH+1:0]        prod_im;
	logic signed [CW-1:0]           re_x;
	logic signed [CW-1:0]           im_x;
	logic                           neg_re;

	always_comb begin
		re_w = {sample.real_part[DATA_WIDTH-1], sample.real_part};
		im_w = {sample.imag_part[DATA_WIDTH-1], sample.imag_part};
		are = re_w[DATA_WIDTH] ? (DATA_WIDTH+1)'(0) - re_w : re_w;
		aim = im_w[DATA_WIDTH] ? (DATA_WIDTH+1)'(0) - im_w : im_w;
		prod_re = are * are;
		prod_im = aim * aim;
		neg_re = sample.real_part[DATA_WIDTH-1];
		re_x = {{(CW-DATA_WIDTH){sample.real_part[DATA_WIDTH-1]}}, sample.real_part};
		im_x = {{(CW-DATA_WIDTH){sample.imag_part[DATA_WIDTH-1]}}, sample.imag_part};

		prep = '0;
		prep.sq_re = prod_re[SW-1:0];
		prep.sq_im = prod_im[SW-1:0];
		// A vector in the left half plane is turned by pi before rotating.
		if (neg_re) begin
			prep.x = (-re_x) <<< PRE_SHIFT;
			prep.y = (-im_x) <<< PRE_SHIFT;
			prep.z = ANG_PI;
		end else begin
			prep.x = re_x <<< PRE_SHIFT;
			prep.y = im_x <<< PRE_SHIFT;
			prep.z = ANG_ZERO;
		end

		if (sample.imag_part == '0) begin
			prep.is_axis = 1'b1;
			prep.axis_z = neg_re ? ANG_PI : ANG_ZERO;
		end else if (sample.real_part == '0) begin
			prep.is_axis = 1'b1;
			prep.axis_z = sample.imag_part[DATA_WIDTH-1] ? ANG_NEG_HPI : ANG_HALF_PI;
		end else begin
			prep.is_axis = 1'b0;
			prep.axis_z = ANG_ZERO;
		end
	end

endmodule

### src/r2p_post.sv
// ----------------------------------------------------------------------------
// Result formatting
// Rounds the square root to nearest, picks the exact axis angle where one
// applies and rounds the angle accumulator to the output width.
// ----------------------------------------------------------------------------
module r2p_post (
	input  r2p_pkg::stage_t  fin,
	output r2p_pkg::result_t res
);
	import r2p_pkg::*;

	logic [RW-1:0] root_rnd;
	logic [AW-1:0] ang;
	logic [AW-1:0] ang_rnd;

	always_comb begin
		// The remainder is s - r*r; round up when it exceeds r.
		root_rnd = ({1'b0, fin.rem} > fin.root) ? fin.root + RW'(1) : fin.root;
		ang = fin.is_axis ? fin.axis_z : fin.z;
		ang_rnd = ang + ANG_HALF;
		res.magnitude = root_rnd[DATA_WIDTH-1:0];
		res.phase_angle = ang_rnd[AW-1 -: DATA_WIDTH];
	end

endmodule

### src/rect_to_polar_converter.sv
// ----------------------------------------------------------------------------
// Rectangular to polar converter
// A request passes the STAGES pipeline registers, then the result register;
// each stage does at most one CORDIC step and one square-root digit. A full
// stage holds while its successor cannot take it; else one request per cycle.
// Reset clears the valid bits of all stages and the output; data is not reset.
// ----------------------------------------------------------------------------
module rect_to_polar_converter (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  r2p_pkg::sample_t sample,
	output logic             result_valid,
	input  logic             result_stall,
	output r2p_pkg::result_t result
);
	import r2p_pkg::*;

	stage_t  prep_c;
	stage_t  pipe_data_s  [1:STAGES];
	logic    pipe_valid_s [1:STAGES];
	logic    stage_ready  [1:STAGES+1];
	result_t post_c;

	r2p_prep u_prep (
		.sample (sample),
		.prep   (prep_c)
	);

	assign sample_stall = !stage_ready[1];
	assign stage_ready[STAGES+1] = !result_valid || !result_stall;

	for (genvar t = 1; t <= STAGES; t++) begin : g_ready
		assign stage_ready[t] = !pipe_valid_s[t] || stage_ready[t+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_valid_s[1] <= 1'b0;
		end else if (stage_ready[1]) begin
			pipe_valid_s[1] <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_ready[1] && sample_valid) begin
			pipe_data_s[1] <= prep_c;
		end
	end

	for (genvar t = 2; t <= STAGES; t++) begin : g_stage
		stage_t          sum_c;
		stage_t          rot_c;
		stage_t          sqr_c;

		if (t == 2) begin : g_sum
			logic [SW:0] sum_w;

			always_comb begin
				sum_w = {1'b0, pipe_data_s[t-1].sq_re} + {1'b0, pipe_data_s[t-1].sq_im};
				sum_c = pipe_data_s[t-1];
				sum_c.rem = sum_w[SW-1:0];
				sum_c.root = '0;
			end
		end else begin : g_pass_sum
			assign sum_c = pipe_data_s[t-1];
		end

		if (t - 2 < ITERATIONS) begin : g_rot
			assign rot_c = cordic_step(sum_c, 5'(t - 2));
		end else begin : g_pass_rot
			assign rot_c = sum_c;
		end

		if (t >= 3 && t - 3 < DATA_WIDTH) begin : g_sqrt
			assign sqr_c = sqrt_step(rot_c, t - 3);
		end else begin : g_pass_sqrt
			assign sqr_c = rot_c;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pipe_valid_s[t] <= 1'b0;
			end else if (stage_ready[t]) begin
				pipe_valid_s[t] <= pipe_valid_s[t-1];
			end
		end

		always_ff @(posedge clk) begin
			if (stage_ready[t] && pipe_valid_s[t-1]) begin
				pipe_data_s[t] <= sqr_c;
			end
		end
	end

	r2p_post u_post (
		.fin (pipe_data_s[STAGES]),
		.res (post_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (stage_ready[STAGES+1]) begin
			result_valid <= pipe_valid_s[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (stage_ready[STAGES+1] && pipe_valid_s[STAGES]) begin
			result <= post_c;
		end
	end

endmodule
